@@ rtl/lrc_time_tag_extractor_macros.svh @@
`ifndef LRC_TIME_TAG_EXTRACTOR_MACROS_SVH
`define LRC_TIME_TAG_EXTRACTOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define LRCTTE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LRCTTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/lrctte_pkg.sv @@
`default_nettype none
package lrctte_pkg;

	localparam int MAX_TAGS    = 16;
	localparam int CNT_W       = $clog2(MAX_TAGS + 1);
	localparam int IDX_W       = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
	localparam int TIME_W      = 26;
	localparam int ROW_W       = 16;
	localparam int BYTE_W      = 8;
	localparam int OUT_W       = TIME_W + ROW_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
	localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
	localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
	localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_LBR   = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_RBR   = 8'h5D;

	typedef enum logic [3:0] {
		PH_OUT  = 4'b0001,
		PH_MIN  = 4'b0010,
		PH_SEC  = 4'b0100,
		PH_FRAC = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		BK_COLLECT = 2'b01,
		BK_EMIT    = 2'b10
	} back_state_t;

	// one queue item: an optional tag time, an optional row end and its emit flag
	typedef struct packed {
		logic              has_time;
		logic              is_end;
		logic              emit;
		logic [TIME_W-1:0] time_ms;
		logic [ROW_W-1:0]  row;
	} entry_t;

	function automatic logic is_blank(input logic [BYTE_W-1:0] b);
		return b inside {CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR};
	endfunction

endpackage
`default_nettype wire

@@ rtl/lrctte_front.sv @@
`default_nettype none
module lrctte_front (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         s_tvalid,
	output logic                        s_tready,
	input  wire [lrctte_pkg::BYTE_W-1:0] s_tdata,   // [7:0] text_byte
	input  wire                         s_tlast,
	input  wire                         q_full,
	output logic                        push,
	output lrctte_pkg::entry_t          push_entry
);
	import lrctte_pkg::*;

	phase_t             phase_q;
	logic [1:0]         dc_q;
	logic [9:0]         mn_q;
	logic [6:0]         sc_q;
	logic [9:0]         fr_q;
	logic [CNT_W-1:0]   tc_q;
	logic               ts_q;
	logic [ROW_W-1:0]   row_q;

	phase_t             phase_d;
	logic [1:0]         dc_d;
	logic [9:0]         mn_d;
	logic [6:0]         sc_d;
	logic [9:0]         fr_d;
	logic [CNT_W-1:0]   tc_d;
	logic               ts_d;
	logic [ROW_W-1:0]   row_d;
	logic               brk;
	logic               fin_tag;
	logic               row_end;
	logic               dig;
	logic [3:0]         dval;
	logic [9:0]         frs;
	logic [TIME_W-1:0]  tag_time;
	logic               acc;

	assign s_tready = !q_full;
	assign acc      = s_tvalid && s_tready;
	assign dig      = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
	assign dval     = 4'(s_tdata - CH_ZERO);

	// fraction left-justified to milliseconds
	always_comb begin
		frs = 10'd0;
		if (phase_q == PH_FRAC) begin
			case (dc_q)
				2'd1:    frs = 10'(fr_q * 10'd100);
				2'd2:    frs = 10'(fr_q * 10'd10);
				default: frs = fr_q;
			endcase
		end
	end

	assign tag_time = 26'(mn_q) * 26'd60000 + 26'(sc_q) * 26'd1000 + 26'(frs);

	always_comb begin
		phase_d = phase_q;
		dc_d    = dc_q;
		mn_d    = mn_q;
		sc_d    = sc_q;
		fr_d    = fr_q;
		tc_d    = tc_q;
		ts_d    = ts_q;
		row_d   = row_q;
		brk     = 1'b0;
		fin_tag = 1'b0;
		row_end = (s_tdata == CH_NL) || s_tlast;
		push_entry = '0;

		if (s_tdata != CH_NL) begin
			case (phase_q)
				PH_MIN: begin
					if (dig && dc_q < 2'd3) begin
						mn_d = 10'(mn_q * 10'd10 + 10'(dval));
						dc_d = dc_q + 2'd1;
					end else if (s_tdata == CH_COLON && dc_q != 2'd0) begin
						phase_d = PH_SEC;
						dc_d    = 2'd0;
					end else begin
						brk = 1'b1;
					end
				end
				PH_SEC: begin
					if (dig && dc_q < 2'd2) begin
						sc_d = 7'(sc_q * 7'd10 + 7'(dval));
						dc_d = dc_q + 2'd1;
					end else if (dc_q == 2'd2 && s_tdata == CH_RBR) begin
						fin_tag = 1'b1;
					end else if (dc_q == 2'd2 && (s_tdata == CH_DOT || s_tdata == CH_COLON)) begin
						phase_d = PH_FRAC;
						dc_d    = 2'd0;
					end else begin
						brk = 1'b1;
					end
				end
				PH_FRAC: begin
					if (dig && dc_q < 2'd3) begin
						fr_d = 10'(fr_q * 10'd10 + 10'(dval));
						dc_d = dc_q + 2'd1;
					end else if (s_tdata == CH_RBR && dc_q != 2'd0) begin
						fin_tag = 1'b1;
					end else begin
						brk = 1'b1;
					end
				end
				default: brk = 1'b1;  // outside: handle as a plain byte
			endcase

			if (brk) begin
				if (phase_q != PH_OUT)
					ts_d = 1'b1;
				phase_d = PH_OUT;
				dc_d    = 2'd0;
				if (s_tdata == CH_LBR) begin
					phase_d = PH_MIN;
					mn_d    = 10'd0;
					sc_d    = 7'd0;
					fr_d    = 10'd0;
				end else if (!is_blank(s_tdata)) begin
					ts_d = 1'b1;
				end
			end

			if (fin_tag) begin
				phase_d = PH_OUT;
				dc_d    = 2'd0;
				if (tc_q < CNT_W'(MAX_TAGS)) begin
					push_entry.has_time = 1'b1;
					tc_d = tc_q + 1'b1;
				end
			end
		end

		push_entry.time_ms = tag_time;
		push_entry.row     = row_q;

		if (row_end) begin
			// a partial tag left open counts as text
			if (phase_d != PH_OUT)
				ts_d = 1'b1;
			push_entry.is_end = 1'b1;
			push_entry.emit   = (tc_d != '0) && ts_d;
			phase_d = PH_OUT;
			dc_d    = 2'd0;
			tc_d    = '0;
			ts_d    = 1'b0;
			if (row_q != '1)
				row_d = row_q + 1'b1;
		end

		if (s_tlast) begin
			phase_d = PH_OUT;
			dc_d    = 2'd0;
			mn_d    = 10'd0;
			sc_d    = 7'd0;
			fr_d    = 10'd0;
			row_d   = '0;
		end
	end

	assign push = acc && (push_entry.has_time || push_entry.is_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OUT;
			dc_q    <= 2'd0;
			mn_q    <= 10'd0;
			sc_q    <= 7'd0;
			fr_q    <= 10'd0;
			tc_q    <= '0;
			ts_q    <= 1'b0;
			row_q   <= '0;
		end else if (acc) begin
			phase_q <= phase_d;
			dc_q    <= dc_d;
			mn_q    <= mn_d;
			sc_q    <= sc_d;
			fr_q    <= fr_d;
			tc_q    <= tc_d;
			ts_q    <= ts_d;
			row_q   <= row_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/lrctte_queue.sv @@
`default_nettype none
module lrctte_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  lrctte_pkg::entry_t  push_entry,
	output logic                full,
	input  wire                 pop,
	output logic                empty,
	output lrctte_pkg::entry_t  pop_entry
);
	import lrctte_pkg::*;

	entry_t              mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_push;
	logic                do_pop;

	assign full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty     = (cnt_q == '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign pop_entry = mem[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

@@ rtl/lrctte_back.sv @@
`default_nettype none
`include "lrc_time_tag_extractor_macros.svh"
module lrctte_back (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              empty,
	input  lrctte_pkg::entry_t               pop_entry,
	output logic                             pop,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [lrctte_pkg::OUT_TDATA_W-1:0] m_tdata,  // [25:0] time_ms, [41:26] row_number
	output logic                             m_tlast     // last_of_row
);
	import lrctte_pkg::*;

	back_state_t        state_q;
	logic [TIME_W-1:0]  buf_q [MAX_TAGS];
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   idx_q;
	logic [ROW_W-1:0]   row_q;
	logic               m_valid_q;
	logic [TIME_W-1:0]  m_time_q;
	logic [ROW_W-1:0]   m_row_q;
	logic               m_last_q;
	logic               load;
	logic               last;

	assign pop  = !empty && (state_q == BK_COLLECT);
	assign load = (state_q == BK_EMIT) && (!m_valid_q || m_tready);
	assign last = (CNT_W'(idx_q) + 1'b1) == cnt_q;

	always_ff @(posedge clk) begin
		if (pop && pop_entry.has_time && cnt_q < CNT_W'(MAX_TAGS))
			buf_q[cnt_q[IDX_W-1:0]] <= pop_entry.time_ms;
		if (pop && pop_entry.is_end)
			row_q <= pop_entry.row;
		if (load) begin
			m_time_q <= buf_q[idx_q];
			m_row_q  <= row_q;
			m_last_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_COLLECT;
			cnt_q     <= '0;
			idx_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (load)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				BK_COLLECT: begin
					if (pop) begin
						if (pop_entry.is_end) begin
							idx_q <= '0;
							if (pop_entry.emit) begin
								state_q <= BK_EMIT;
								if (pop_entry.has_time)
									cnt_q <= cnt_q + 1'b1;
							end else begin
								cnt_q <= '0;
							end
						end else if (pop_entry.has_time) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				BK_EMIT: begin
					if (load) begin
						idx_q <= idx_q + 1'b1;
						if (last) begin
							state_q <= BK_COLLECT;
							cnt_q   <= '0;
						end
					end
				end
				default: state_q <= BK_COLLECT;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {(OUT_TDATA_W - OUT_W)'(0), m_row_q, m_time_q};

	`LRCTTE_ASSERT_NOW(a_emit_nonempty, state_q == BK_EMIT, cnt_q != '0, "emitting an empty row")
	`LRCTTE_ASSERT_NOW(a_idx_in_row, state_q == BK_EMIT, CNT_W'(idx_q) < cnt_q, "read past row end")
	`LRCTTE_ASSERT_NEXT(a_last_returns, load && last, state_q == BK_COLLECT && cnt_q == '0, "row not closed after last item")

endmodule
`default_nettype wire

@@ rtl/lrc_time_tag_extractor.sv @@
// One text byte per cycle is taken while the 4-entry queue to the emitter has room.
// A row's times pass the queue, the emitter state and the output register after its ending
// byte is taken, then leave one per cycle while m_tready is high. The emitter pops no
// queue entries while it sends a row's tags; the front stalls only when the queue fills.
// arst_n (async, active low) clears parser, row counter, queue and output valid.
`default_nettype none
module lrc_time_tag_extractor (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire [lrctte_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] text_byte
	input  wire                                s_tlast,   // final_byte
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [lrctte_pkg::OUT_TDATA_W-1:0] m_tdata,   // [25:0] time_ms, [41:26] row_number
	output logic                               m_tlast    // last_of_row
);
	import lrctte_pkg::*;

	logic   q_full;
	logic   q_empty;
	logic   push;
	logic   pop;
	entry_t push_entry;
	entry_t pop_entry;

	lrctte_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	lrctte_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.empty      (q_empty),
		.pop_entry  (pop_entry)
	);

	lrctte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.pop_entry (pop_entry),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

@@ verif/lrc_time_tag_extractor_tb.sv @@
`timescale 1ns / 1ps
module lrc_time_tag_extractor_tb;
	import lrctte_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_ITEMS = 230;

	typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH} flow_mode_t;

	typedef struct {
		logic [BYTE_W-1:0] text;
		logic              fin;
		flow_mode_t        mode;
		bit                drain;
	} text_item_t;

	typedef struct {
		logic [TIME_W-1:0] ms;
		logic [ROW_W-1:0]  row;
		logic              last;
	} tag_time_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [BYTE_W-1:0]      s_tdata = '0;
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;

	text_item_t text_items[$];
	tag_time_t  tag_times[$];
	flow_mode_t sent_mode = FLOW_FREE;
	int         mismatches = 0;
	int         quiet_cycles = 0;

	// parser copy
	phase_t            tag_state = PH_OUT;
	int unsigned       ndig = 0, mins = 0, secs = 0, frac_acc = 0, tags_held = 0;
	int unsigned       row_idx = 0;
	bit                lyric_seen = 0;
	logic [TIME_W-1:0] held_ms [MAX_TAGS];

	lrc_time_tag_extractor uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),     // [7:0] text_byte
		.s_tlast(s_tlast),     // final_byte
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),     // [25:0] time_ms, [41:26] row_number
		.m_tlast(m_tlast)      // last_of_row
	);

	always #6 clk = ~clk;

	function automatic bit is_space(logic [BYTE_W-1:0] b);
		return b inside {CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR};
	endfunction

	task automatic plain_byte(logic [BYTE_W-1:0] b);
		if (b == CH_LBR) begin
			tag_state = PH_MIN;
			ndig = 0;
			mins = 0;
			secs = 0;
			frac_acc = 0;
		end else if (!is_space(b)) begin
			lyric_seen = 1;
		end
	endtask

	task automatic close_tag();
		int unsigned f;
		f = 0;
		if (tag_state == PH_FRAC)
			f = (ndig == 1) ? frac_acc * 100 : (ndig == 2) ? frac_acc * 10 : frac_acc;
		if (tags_held < MAX_TAGS) begin
			held_ms[tags_held] = TIME_W'(mins * 60000 + secs * 1000 + f);
			tags_held++;
		end
		tag_state = PH_OUT;
		ndig = 0;
	endtask

	// a partial tag counts as lyric text
	task automatic drop_tag();
		if (tag_state != PH_OUT)
			lyric_seen = 1;
		tag_state = PH_OUT;
		ndig = 0;
	endtask

	task automatic end_row();
		drop_tag();
		if (tags_held != 0 && lyric_seen) begin
			for (int i = 0; i < tags_held; i++)
				tag_times.push_back('{held_ms[i], ROW_W'(row_idx), (i + 1 == tags_held)});
		end
		tags_held = 0;
		lyric_seen = 0;
		if (row_idx < 16'hFFFF)
			row_idx++;
	endtask

	task automatic take_byte(logic [BYTE_W-1:0] b, logic fin);
		bit          dig;
		bit          taken;
		int unsigned d;
		dig = (b >= CH_ZERO && b <= CH_NINE);
		d = b - CH_ZERO;
		if (b == CH_NL) begin
			end_row();
		end else begin
			taken = 0;
			case (tag_state)
				PH_MIN: begin
					if (dig && ndig < 3) begin
						mins = mins * 10 + d;
						ndig++;
						taken = 1;
					end else if (b == CH_COLON && ndig >= 1) begin
						tag_state = PH_SEC;
						ndig = 0;
						taken = 1;
					end
				end
				PH_SEC: begin
					if (dig && ndig < 2) begin
						secs = secs * 10 + d;
						ndig++;
						taken = 1;
					end else if (ndig == 2 && b == CH_RBR) begin
						close_tag();
						taken = 1;
					end else if (ndig == 2 && (b == CH_DOT || b == CH_COLON)) begin
						tag_state = PH_FRAC;
						ndig = 0;
						taken = 1;
					end
				end
				PH_FRAC: begin
					if (dig && ndig < 3) begin
						frac_acc = frac_acc * 10 + d;
						ndig++;
						taken = 1;
					end else if (b == CH_RBR && ndig >= 1) begin
						close_tag();
						taken = 1;
					end
				end
				default: ;
			endcase
			if (!taken) begin
				drop_tag();
				plain_byte(b);
			end
			if (fin)
				end_row();
		end
		if (fin) begin
			tag_state = PH_OUT;
			ndig = 0;
			mins = 0;
			secs = 0;
			frac_acc = 0;
			tags_held = 0;
			lyric_seen = 0;
			row_idx = 0;
		end
	endtask

	// stimulus builders
	task automatic push_str(string s, bit fin);
		for (int i = 0; i < s.len(); i++)
			text_items.push_back('{s[i], fin && (i == s.len() - 1), FLOW_FREE, 1'b0});
	endtask

	function automatic logic [BYTE_W-1:0] lyric_char();
		int unsigned       r;
		logic [BYTE_W-1:0] b;
		r = $urandom_range(9);
		if (r < 5) begin
			b = BYTE_W'(8'h61 + $urandom_range(25));
		end else if (r < 7) begin
			case ($urandom_range(4))
				0: b = CH_SP;
				1: b = CH_TAB;
				2: b = CH_VT;
				3: b = CH_FF;
				default: b = CH_CR;
			endcase
		end else begin
			do b = BYTE_W'($urandom_range(255, 1)); while (b == CH_NL);
		end
		return b;
	endfunction

	task automatic add_text(ref logic [BYTE_W-1:0] rq[$]);
		repeat ($urandom_range(4, 1)) rq.push_back(lyric_char());
	endtask

	task automatic build_tag(ref logic [BYTE_W-1:0] rq[$]);
		logic [BYTE_W-1:0] tq[$];
		int                pos;
		logic [BYTE_W-1:0] b;
		tq.push_back(CH_LBR);
		repeat ($urandom_range(3, 1)) tq.push_back(BYTE_W'(CH_ZERO + $urandom_range(9)));
		tq.push_back(CH_COLON);
		repeat (2) tq.push_back(BYTE_W'(CH_ZERO + $urandom_range(9)));
		case ($urandom_range(2))
			1: tq.push_back(CH_DOT);
			2: tq.push_back(CH_COLON);
			default: ;
		endcase
		if (tq[tq.size() - 1] == CH_DOT || tq[tq.size() - 1] == CH_COLON)
			repeat ($urandom_range(3, 1)) tq.push_back(BYTE_W'(CH_ZERO + $urandom_range(9)));
		tq.push_back(CH_RBR);
		if ($urandom_range(99) < 15) begin
			pos = $urandom_range(tq.size() - 1);
			if ($urandom_range(1)) begin
				tq = tq[0:pos];
			end else begin
				do b = BYTE_W'($urandom_range(255, 1)); while (b == CH_NL);
				tq[pos] = b;
			end
		end
		foreach (tq[i]) rq.push_back(tq[i]);
	endtask

	task automatic add_row(flow_mode_t mode, bit drain);
		logic [BYTE_W-1:0] rq[$];
		int                r;
		int                nt;
		bit                fin;
		r = $urandom_range(99);
		nt = (r < 8) ? 0 : (r < 85) ? $urandom_range(3, 1) :
			(r < 95) ? $urandom_range(8, 4) : $urandom_range(18, 16);
		repeat (nt) begin
			if ($urandom_range(3) == 0)
				add_text(rq);
			build_tag(rq);
		end
		if ($urandom_range(9) < 8)
			add_text(rq);
		r = $urandom_range(19);
		fin = (r < 2);
		if (r == 0) begin
			if (rq.size() == 0)
				rq.push_back(lyric_char());
		end else begin
			rq.push_back(CH_NL);
		end
		foreach (rq[i])
			text_items.push_back('{rq[i], fin && (i == rq.size() - 1), mode, drain && (i == 0)});
	endtask

	// driver
	always @(posedge clk) begin : drive_proc
		logic              nv;
		logic [BYTE_W-1:0] nd;
		logic              nl;
		bit                hold;
		text_item_t        it;
		if (arst_n) begin
			nv = s_tvalid;
			nd = s_tdata;
			nl = s_tlast;
			if (!s_tvalid || s_tready) begin
				nv = 1'b0;
				if (text_items.size() != 0) begin
					case (text_items[0].mode)
						FLOW_SRC_IDLE: hold = ($urandom_range(99) < 67);
						FLOW_BOTH:     hold = ($urandom_range(99) < 15);
						default:       hold = 0;
					endcase
					// pause until every pending time has drained
					if (text_items[0].drain && (s_tvalid || tag_times.size() != 0))
						hold = 1;
					if (!hold) begin
						it = text_items.pop_front();
						nv = 1'b1;
						nd = it.text;
						nl = it.fin;
						sent_mode <= it.mode;
					end
				end
			end
			s_tvalid <= nv;
			s_tdata <= nd;
			s_tlast <= nl;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			case (sent_mode)
				FLOW_SINK_STALL: m_tready <= ($urandom_range(99) >= 67);
				FLOW_BOTH:       m_tready <= ($urandom_range(99) >= 15);
				default:         m_tready <= 1'b1;
			endcase
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin : watch_proc
		tag_time_t exp_t;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (tag_times.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected time item: ms=%0d row=%0d last=%0b",
							m_tdata[TIME_W-1:0], m_tdata[TIME_W +: ROW_W], m_tlast);
					mismatches++;
				end else begin
					exp_t = tag_times.pop_front();
					if (m_tdata[TIME_W-1:0] !== exp_t.ms || m_tdata[TIME_W +: ROW_W] !== exp_t.row
						|| m_tlast !== exp_t.last) begin
						if (mismatches < 10)
							$display("mismatch: exp ms=%0d row=%0d last=%0b, got ms=%0d row=%0d last=%0b",
								exp_t.ms, exp_t.row, exp_t.last, m_tdata[TIME_W-1:0],
								m_tdata[TIME_W +: ROW_W], m_tlast);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready)
				take_byte(s_tdata, s_tlast);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("lrc_time_tag_extractor_tb: errors");
				$finish;
			end
		end
	end

	initial begin : stim_proc
		int start;
		int row_n;
		push_str("[0:00]x\n", 0);
		push_str("[999:99.999][5:07.5]A\n", 0);
		push_str("[12:34:56]b\n", 0);
		push_str("[1:2]c[3:045][x][[1:00]d\n", 0);
		push_str("[1:00] \t\r", 0);
		text_items.push_back('{CH_VT, 1'b0, FLOW_FREE, 1'b0});
		text_items.push_back('{CH_FF, 1'b0, FLOW_FREE, 1'b0});
		push_str("\n", 0);
		push_str("hello\n", 0);
		push_str("[2:00]e[3:0\n", 0);
		push_str("[0:01]", 0);
		text_items.push_back('{8'h80, 1'b0, FLOW_FREE, 1'b0});
		text_items.push_back('{8'hFF, 1'b0, FLOW_FREE, 1'b0});
		push_str("\n", 0);
		push_str("[3:45]y\n", 1);
		push_str("[0:10.1]z", 1);
		push_str("[1:23]s\n", 0);
		push_str("[2:00]t", 1);
		start = text_items.size();
		row_n = 0;
		while (text_items.size() - start < RANDOM_ITEMS) begin
			add_row(flow_mode_t'(row_n % 4), (row_n % 3) == 1);
			row_n++;
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (text_items.size() != 0 || s_tvalid) @(posedge clk);
		while (tag_times.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && tag_times.size() == 0)
			$display("lrc_time_tag_extractor_tb: clean");
		else
			$display("lrc_time_tag_extractor_tb: errors");
		$finish;
	end

endmodule
